// File: design/pjt_pkg.sv
// ----------------------------------------------------------------------------
// pjt_pkg: shared types and constants of the periodic job timer table
// Field widths, operation and result codes, the table entry and the command
// broadcast to the row of table cells.
// ----------------------------------------------------------------------------
package pjt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_W       = 16;
   localparam int TIME_W      = 32;
   localparam int OP_W        = 2;
   localparam int KIND_W      = 2;

   localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

   // Request operation codes
   localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUM   = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] last_run;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_UPDATE,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTATE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now;
   } cmd_type;

endpackage

// File: design/pjt_req_if.sv
// ----------------------------------------------------------------------------
// pjt_req_if: request channel of the periodic job timer table
// Valid/ready channel carrying one job operation per transaction.
// ----------------------------------------------------------------------------
interface pjt_req_if;
   logic                      valid;
   logic                      ready;
   logic [pjt_pkg::OP_W-1:0]   opcode;
   logic [pjt_pkg::KEY_W-1:0]  job_key;
   logic [pjt_pkg::TIME_W-1:0] interval;
   logic [pjt_pkg::TIME_W-1:0] now;

   modport source (output valid, opcode, job_key, interval, now, input ready);
   modport sink   (input valid, opcode, job_key, interval, now, output ready);
endinterface

// File: design/pjt_rsp_if.sv
// ----------------------------------------------------------------------------
// pjt_rsp_if: response channel of the periodic job timer table
// Valid/ready channel carrying acknowledge, fired and summary transactions.
// ----------------------------------------------------------------------------
interface pjt_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pjt_pkg::KIND_W-1:0] kind;
   logic [pjt_pkg::KEY_W-1:0]  fired_key;
   logic [pjt_pkg::TIME_W-1:0] time_left;
   logic                       status;
   logic                       last;

   modport source (output valid, kind, fired_key, time_left, status, last, input ready);
   modport sink   (input valid, kind, fired_key, time_left, status, last, output ready);
endinterface

// File: design/pjt_cell.sv
// ----------------------------------------------------------------------------
// pjt_cell: one slot of the sorted job table
// Holds one entry. Valid entries stay packed at the head of the row in
// ascending key order; the cell shifts right on insert, left on delete and
// left on every step of a tick walk.
// ----------------------------------------------------------------------------
module pjt_cell (
   input  logic               clock,
   input  logic               reset,
   input  pjt_pkg::cmd_type   cmd,
   input  pjt_pkg::entry_type left_ent,
   input  logic               left_pos,
   input  pjt_pkg::entry_type right_ent,
   input  logic               seen_in,
   output pjt_pkg::entry_type ent,
   output logic               pos,
   output logic               seen_out
);
   import pjt_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;
   logic      match;

   // Compare own key against the command key
   assign match    = ent_ff.valid && (ent_ff.key == cmd.key);
   assign pos      = !ent_ff.valid || (ent_ff.key > cmd.key);
   assign seen_out = seen_in | match;
   assign ent      = ent_ff;

   // Select next content from command and neighbors
   always_comb begin
      ent_in = ent_ff;
      case (cmd.op)
         CMD_UPDATE: begin
            if (match) begin
               ent_in.period   = cmd.period;
               ent_in.last_run = cmd.now;
            end
         end
         CMD_INSERT: begin
            if (left_pos) begin
               ent_in = left_ent;
            end else if (pos) begin
               ent_in.valid    = 1'b1;
               ent_in.key      = cmd.key;
               ent_in.period   = cmd.period;
               ent_in.last_run = cmd.now;
            end
         end
         CMD_DELETE: begin
            if (seen_out) begin
               ent_in = right_ent;
            end
         end
         CMD_ROTATE: begin
            ent_in = right_ent;
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   // Hold the entry; reset clears only the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule

// File: design/periodic_job_timer_table_unit.sv
// ----------------------------------------------------------------------------
// periodic_job_timer_table_unit: sorted table of periodic jobs
// Row of table cells plus a controller that serves add, delete and tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per transaction: add/update a job, delete a
//   job, or tick with the current time. rsp_ch returns the results; the last
//   result of each request has last set.
//   Add and delete update the row of cells in the cycle the request is taken
//   and return one acknowledge from the output register in the next cycle.
//   A tick rotates the whole row through the head cell, one cell per cycle
//   while the receiver does not stall, and then issues a summary. Each job
//   due at the head emits a fired transaction, in ascending key order, and
//   the summary carries the least remaining time.
//   A new request is taken only when the previous one is complete and the
//   output register is free or being emptied; an add or delete therefore
//   sustains one request every cycle; a tick holds new ones until its summary.
//   When rsp_ch stalls, the walk holds at its current cell until the waiting
//   transaction is taken.
//   Reset (synchronous) empties the table and the output register.
// ----------------------------------------------------------------------------
module periodic_job_timer_table_unit (
   input  logic clock,
   input  logic reset,
   pjt_req_if.sink   req_ch,
   pjt_rsp_if.source rsp_ch
);
   import pjt_pkg::*;

   localparam int CNT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_SUM
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] least_ff, least_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [TIME_W-1:0] rsp_left_ff, rsp_left_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   cmd_type   cmd;
   entry_type ents [TABLE_DEPTH];
   logic      poss [TABLE_DEPTH];
   logic      seen [TABLE_DEPTH+1];
   entry_type tail_in;
   entry_type head;

   logic              out_free;
   logic              req_fire;
   logic              any_match;
   logic              full;
   logic [TIME_W-1:0] elapsed;
   logic              due;
   logic [TIME_W-1:0] left;

   // Build the row of cells
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type l_ent;
      logic      l_pos;
      entry_type r_ent;
      if (i == 0) begin : g_head
         assign l_ent = '0;
         assign l_pos = 1'b0;
      end else begin : g_mid
         assign l_ent = ents[i-1];
         assign l_pos = poss[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign r_ent = tail_in;
      end else begin : g_body
         assign r_ent = ents[i+1];
      end
      pjt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .left_ent  (l_ent),
         .left_pos  (l_pos),
         .right_ent (r_ent),
         .seen_in   (seen[i]),
         .ent       (ents[i]),
         .pos       (poss[i]),
         .seen_out  (seen[i+1])
      );
   end

   assign any_match = seen[TABLE_DEPTH];
   assign full      = ents[TABLE_DEPTH-1].valid;
   assign head      = ents[0];

   // Evaluate the job at the head of the row
   assign elapsed = now_ff - head.last_run;
   assign due     = elapsed >= head.period;
   assign left    = due ? head.period : (head.period - elapsed);

   // Recirculate the head entry into the tail during a walk
   always_comb begin
      tail_in = '0;
      if (cmd.op == CMD_ROTATE) begin
         tail_in = head;
         if (due) begin
            tail_in.last_run = now_ff;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_ch.ready     = (state_ff == S_IDLE) && out_free;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.kind      = rsp_kind_ff;
   assign rsp_ch.fired_key = rsp_key_ff;
   assign rsp_ch.time_left = rsp_left_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // Sequence requests and load the output register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      now_in        = now_ff;
      least_in      = least_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = CMD_NONE;
      cmd.key       = req_ch.job_key;
      cmd.period    = req_ch.interval;
      cmd.now       = req_ch.now;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_ch.opcode)
                  OP_ADD: begin
                     if (any_match) begin
                        cmd.op = CMD_UPDATE;
                     end else if (!full) begin
                        cmd.op = CMD_INSERT;
                     end
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_ACK;
                     rsp_key_in    = req_ch.job_key;
                     rsp_left_in   = '0;
                     rsp_status_in = !any_match && full;
                     rsp_last_in   = 1'b1;
                  end
                  OP_DEL: begin
                     cmd.op        = CMD_DELETE;
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_ACK;
                     rsp_key_in    = req_ch.job_key;
                     rsp_left_in   = '0;
                     rsp_status_in = 1'b0;
                     rsp_last_in   = 1'b1;
                  end
                  OP_TICK: begin
                     now_in   = req_ch.now;
                     least_in = ALL_ONES;
                     count_in = '0;
                     state_in = S_WALK;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (out_free) begin
               cmd.op = CMD_ROTATE;
               if (head.valid) begin
                  if (left < least_ff) begin
                     least_in = left;
                  end
                  if (due) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_FIRED;
                     rsp_key_in    = head.key;
                     rsp_left_in   = '0;
                     rsp_status_in = 1'b0;
                     rsp_last_in   = 1'b0;
                  end
               end
               count_in = count_ff + 1'b1;
               if (count_ff == CNT_W'(TABLE_DEPTH - 1)) begin
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_SUM;
               rsp_key_in    = '0;
               rsp_left_in   = least_ff;
               rsp_status_in = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff        <= now_in;
      least_ff      <= least_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for periodic_job_timer_table_unit
// Drives add, delete and tick transactions into the job table, predicts every
// acknowledge, fired and summary transaction with a local copy of the table,
// and compares each response field by field in arrival order. A directed
// table covers the empty, full and wrap-around corners. Random traffic with
// stalls on both channels follows.
// ----------------------------------------------------------------------------
module tb;
   import pjt_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RAND_ITEMS = 285;
   localparam int CALM_ITEMS = 40;
   localparam int POOL_SIZE  = 24;
   localparam int MAX_REPORTS = 60;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] ival;
      logic [TIME_W-1:0] now;
   } job_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] left;
      logic              status;
      logic              last;
   } job_rsp_type;

   typedef struct packed {
      job_req_type req;
      logic        typed;
      job_rsp_type rsp;
   } plan_row_type;

   logic clock;
   logic reset;

   pjt_req_if req_ch ();
   pjt_rsp_if rsp_ch ();

   periodic_job_timer_table_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Local copy of the job table
   logic              slot_valid    [TABLE_DEPTH];
   logic [KEY_W-1:0]  slot_key      [TABLE_DEPTH];
   logic [TIME_W-1:0] slot_period   [TABLE_DEPTH];
   logic [TIME_W-1:0] slot_last_run [TABLE_DEPTH];

   job_rsp_type       step_rsp [$];
   job_rsp_type       awaited_rsp [$];
   plan_row_type      plan [$];
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];
   logic [TIME_W-1:0] cur_now;
   int                errors;
   int                reports;
   int                stall_left;
   bit                calm;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic job_rsp_type make_rsp(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                            logic [TIME_W-1:0] left, logic status,
                                            logic last);
      job_rsp_type r;
      r.kind   = kind;
      r.key    = key;
      r.left   = left;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   // Append one response to the responses of the current step
   function automatic void add_step_rsp(job_rsp_type r);
      step_rsp.insert(step_rsp.size(), r);
   endfunction

   // Apply one request to the local table and collect its responses in step_rsp
   function automatic void predict_job_op(job_req_type q);
      int               slot;
      int               pick;
      bit               have_prev;
      logic [KEY_W-1:0] prev;
      logic [TIME_W-1:0] least;
      logic [TIME_W-1:0] left;
      slot = -1;
      step_rsp.delete();
      case (q.op)
         OP_ADD, OP_DEL: begin
            for (int i = 0; i < TABLE_DEPTH; i++)
               if (slot < 0 && slot_valid[i] && slot_key[i] == q.key) slot = i;
            if (q.op == OP_DEL) begin
               if (slot >= 0) slot_valid[slot] = 1'b0;
               add_step_rsp(make_rsp(KIND_ACK, q.key, '0, 1'b0, 1'b1));
            end else begin
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (slot < 0 && !slot_valid[i]) slot = i;
               if (slot < 0) begin
                  add_step_rsp(make_rsp(KIND_ACK, q.key, '0, 1'b1, 1'b1));
               end else begin
                  slot_valid[slot]    = 1'b1;
                  slot_key[slot]      = q.key;
                  slot_period[slot]   = q.ival;
                  slot_last_run[slot] = q.now;
                  add_step_rsp(make_rsp(KIND_ACK, q.key, '0, 1'b0, 1'b1));
               end
            end
         end
         OP_TICK: begin
            least     = ALL_ONES;
            have_prev = 1'b0;
            prev      = '0;
            // visit jobs in ascending key order
            for (int n = 0; n < TABLE_DEPTH; n++) begin
               pick = -1;
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (slot_valid[i] && !(have_prev && slot_key[i] <= prev) &&
                      (pick < 0 || slot_key[i] < slot_key[pick]))
                     pick = i;
               if (pick >= 0) begin
                  prev      = slot_key[pick];
                  have_prev = 1'b1;
                  if (TIME_W'(q.now - slot_last_run[pick]) >= slot_period[pick]) begin
                     slot_last_run[pick] = q.now;
                     add_step_rsp(make_rsp(KIND_FIRED, slot_key[pick], '0, 1'b0, 1'b0));
                  end
                  left = slot_period[pick] + slot_last_run[pick] - q.now;
                  if (left < least) least = left;
               end
            end
            add_step_rsp(make_rsp(KIND_SUM, '0, least, 1'b0, 1'b1));
         end
         default: ;
      endcase
   endfunction

   function automatic void add_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [TIME_W-1:0] ival, logic [TIME_W-1:0] now,
                                   logic typed, job_rsp_type rsp);
      plan_row_type r;
      r.req.op   = op;
      r.req.key  = key;
      r.req.ival = ival;
      r.req.now  = now;
      r.typed    = typed;
      r.rsp      = rsp;
      plan.insert(plan.size(), r);
   endfunction

   // Draw a random request; keys mostly from a small pool so jobs get reused
   function automatic job_req_type random_job();
      job_req_type q;
      int          pct;
      pct = $urandom_range(0, 99);
      if (pct < 40)      q.op = OP_ADD;
      else if (pct < 60) q.op = OP_DEL;
      else if (pct < 96) q.op = OP_TICK;
      else               q.op = OP_UNUSED;
      if ($urandom_range(0, 99) < 85) q.key = key_pool[$urandom_range(0, POOL_SIZE-1)];
      else                            q.key = KEY_W'($urandom);
      pct = $urandom_range(0, 99);
      if (pct < 15)      q.ival = '0;
      else if (pct < 65) q.ival = $urandom_range(1, 60);
      else if (pct < 85) q.ival = $urandom_range(61, 2000);
      else               q.ival = $urandom;
      // advance time, with the odd jump and wrap
      pct = $urandom_range(0, 99);
      if (pct < 4)      cur_now = $urandom;
      else if (pct < 7) cur_now = ALL_ONES - $urandom_range(0, 60);
      else              cur_now = cur_now + $urandom_range(0, 40);
      q.now = cur_now;
      return q;
   endfunction

   // Send one transaction, with an optional gap first; returns after acceptance
   task automatic send_job(job_req_type q);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.opcode   = q.op;
      req_ch.job_key  = q.key;
      req_ch.interval = q.ival;
      req_ch.now      = q.now;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   task automatic wait_drained();
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic void note_field(string name, logic [TIME_W-1:0] exp_v,
                                      logic [TIME_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         reports++;
      end
   endfunction

   // Response receiver: ready drops in random bursts
   initial begin
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready = 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(0, 12);
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Check each response transaction against the oldest expectation
   always @(posedge clock) begin
      job_rsp_type head;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_rsp.size() == 0) begin
            errors++;
            if (reports < MAX_REPORTS)
               $display("%0t: unexpected response, expected none actual kind %h key %h",
                        $time, rsp_ch.kind, rsp_ch.fired_key);
            reports++;
         end else begin
            head = awaited_rsp.pop_front();
            note_field("kind", TIME_W'(head.kind), TIME_W'(rsp_ch.kind));
            note_field("fired_key", TIME_W'(head.key), TIME_W'(rsp_ch.fired_key));
            note_field("time_left", head.left, rsp_ch.time_left);
            note_field("status", TIME_W'(head.status), TIME_W'(rsp_ch.status));
            note_field("last", TIME_W'(head.last), TIME_W'(rsp_ch.last));
         end
      end
   end

   // Stimulus
   initial begin
      job_req_type q;
      job_rsp_type ack_ok;
      job_rsp_type none;
      int          sent;
      errors  = 0;
      reports = 0;
      calm    = 1'b0;
      cur_now = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) slot_valid[i] = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = OP_ADD;
      req_ch.job_key  = '0;
      req_ch.interval = '0;
      req_ch.now      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      none = '0;
      add_row(OP_TICK, 16'h0000, 32'h0, 32'h0, 1'b1,
              make_rsp(KIND_SUM, '0, ALL_ONES, 1'b0, 1'b1));   // empty table
      add_row(OP_DEL, 16'hffff, 32'h0, 32'h0, 1'b1,
              make_rsp(KIND_ACK, 16'hffff, '0, 1'b0, 1'b1));   // missing key
      add_row(OP_ADD, 16'hffff, ALL_ONES, ALL_ONES, 1'b1,
              make_rsp(KIND_ACK, 16'hffff, '0, 1'b0, 1'b1));
      add_row(OP_ADD, 16'h0000, 32'h0, 32'h5, 1'b1,
              make_rsp(KIND_ACK, 16'h0000, '0, 1'b0, 1'b1));   // zero interval
      add_row(OP_TICK, 16'h1234, 32'h0, 32'h0, 1'b0, none);   // wrapped elapsed time
      add_row(OP_ADD, 16'h0000, 32'd100, 32'd10, 1'b0, none);  // update in place
      // fill the table with a walking-one key
      for (int n = 0; n < TABLE_DEPTH - 2; n++)
         add_row(OP_ADD, 16'h1 << n, 32'd7 * n, 32'h10 + n, 1'b0, none);
      add_row(OP_ADD, 16'h1234, 32'h5, 32'h20, 1'b1,
              make_rsp(KIND_ACK, 16'h1234, '0, 1'b1, 1'b1));   // full, dropped
      add_row(OP_ADD, 16'h0004, 32'h8000_0000, 32'h20, 1'b1,
              make_rsp(KIND_ACK, 16'h0004, '0, 1'b0, 1'b1));   // update while full
      add_row(OP_TICK, 16'h0000, 32'h0, 32'h8000_0000, 1'b0, none);
      add_row(OP_UNUSED, 16'hffff, ALL_ONES, ALL_ONES, 1'b0, none);
      add_row(OP_DEL, 16'hffff, 32'h0, 32'h0, 1'b1,
              make_rsp(KIND_ACK, 16'hffff, '0, 1'b0, 1'b1));
      add_row(OP_TICK, 16'h0000, 32'h0, ALL_ONES, 1'b0, none);

      foreach (plan[i]) begin
         send_job(plan[i].req);
         predict_job_op(plan[i].req);
         if (plan[i].typed) awaited_rsp.insert(awaited_rsp.size(), plan[i].rsp);
         else foreach (step_rsp[j]) awaited_rsp.insert(awaited_rsp.size(), step_rsp[j]);
      end
      // hold off until the directed part has fully drained
      @(negedge clock);
      req_ch.valid = 1'b0;
      wait_drained();

      // Random traffic; unused opcodes do not count
      cur_now = plan[plan.size()-1].req.now;
      sent = 0;
      while (sent < RAND_ITEMS) begin
         calm = (sent >= RAND_ITEMS - CALM_ITEMS);
         q = random_job();
         send_job(q);
         predict_job_op(q);
         foreach (step_rsp[j]) awaited_rsp.insert(awaited_rsp.size(), step_rsp[j]);
         if (q.op != OP_UNUSED) sent++;
         if (sent == RAND_ITEMS / 2 && q.op != OP_UNUSED) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            wait_drained();
         end
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      // Drain, then keep watching for stray responses before the verdict
      wait_drained();
      repeat (TABLE_DEPTH * 3) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
design/pjt_pkg.sv
design/pjt_req_if.sv
design/pjt_rsp_if.sv
design/pjt_cell.sv
design/periodic_job_timer_table_unit.sv
tb/sv/tb.sv
